@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hw/rtl/fbeh_pkg.sv @@
// Package: constants, types and float compare for the histogram unit
package fbeh_pkg;
	localparam int MaxBins   = 32;
	localparam int EdgeDepth = MaxBins + 1;
	localparam int BinW      = $clog2(MaxBins);
	localparam int SlotW     = 6;
	localparam int CountW    = 31;
	localparam int CfgW      = 6;
	localparam logic [CfgW-1:0] BinCountReset = CfgW'(MaxBins);
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_RMW,
		ST_RD_ADDR,
		ST_RD_OUT
	} state_t;

	typedef struct packed {
		logic load_edge;
		logic start_cmp;
		logic rmw;
		logic clear_all;
		logic rd_start;
		logic rd_next;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic rd_last;
	} sts_t;

	// IEEE-754 a <= b, false if either is NaN; -0 == +0
	function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
		logic an, bn, az;
		an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		az = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
		if (an || bn)
			return 1'b0;
		else if (az)
			return 1'b1;
		else if (a[31] != b[31])
			return a[31];
		else if (!a[31])
			return a[30:0] <= b[30:0];
		else
			return a[30:0] >= b[30:0];
	endfunction
endpackage

@@ hw/rtl/fbeh_if.sv @@
// Valid/ready channel interfaces
interface fbeh_in_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [fbeh_pkg::SlotW-1:0] edge_slot;
	logic [31:0] value_bits;
	modport source (output valid, op, edge_slot, value_bits, input ready);
	modport sink (input valid, op, edge_slot, value_bits, output ready);
endinterface

interface fbeh_out_if;
	logic valid;
	logic ready;
	logic [fbeh_pkg::BinW-1:0] bin_index;
	logic [fbeh_pkg::CountW-1:0] bin_total;
	logic last;
	modport source (output valid, bin_index, bin_total, last, input ready);
	modport sink (input valid, bin_index, bin_total, last, output ready);
endinterface

interface fbeh_cfg_if;
	logic valid;
	logic ready;
	logic [fbeh_pkg::CfgW-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/fbeh_datapath.sv @@
// Datapath: edge registers, parallel compares, bin counters, readout
`include "assert_macros.svh"
module fbeh_datapath (
	input  logic clk,
	input  logic arst_n,
	input  fbeh_pkg::cmd_t cmd,
	output fbeh_pkg::sts_t sts,
	input  logic [fbeh_pkg::SlotW-1:0] edge_slot,
	input  logic [31:0] value_bits,
	input  logic [fbeh_pkg::CfgW-1:0] bin_count,
	output logic [fbeh_pkg::BinW-1:0] bin_index,
	output logic [fbeh_pkg::CountW-1:0] bin_total,
	output logic last
);
	localparam int BW = fbeh_pkg::BinW;
	logic [31:0] edge_q [fbeh_pkg::EdgeDepth];
	logic [fbeh_pkg::CountW-1:0] count_q [fbeh_pkg::MaxBins];
	logic [fbeh_pkg::MaxBins-1:0] ge_s1, le_s1, match;
	logic [BW-1:0] hit_bin, rd_q;
	logic [BW:0] used;

	always_comb begin
		if (bin_count == '0)
			used = (BW+1)'(1);
		else if (bin_count > fbeh_pkg::CfgW'(fbeh_pkg::MaxBins))
			used = (BW+1)'(fbeh_pkg::MaxBins);
		else
			used = bin_count[BW:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_edge && edge_slot <= fbeh_pkg::SlotW'(fbeh_pkg::MaxBins))
			edge_q[edge_slot] <= value_bits;
	end

	always_ff @(posedge clk) begin
		if (cmd.start_cmp) begin
			for (int l = 0; l < fbeh_pkg::MaxBins; l++) begin
				ge_s1[l] <= fbeh_pkg::f_le(edge_q[l], value_bits) &&
					((BW+1)'(l) < used);
				le_s1[l] <= fbeh_pkg::f_le(value_bits, edge_q[l+1]);
			end
		end
	end

	// first-match priority select
	assign match = ge_s1 & le_s1;
	assign sts.hit = |match;

	always_comb begin
		hit_bin = '0;
		for (int l = fbeh_pkg::MaxBins - 1; l >= 0; l--)
			if (match[l])
				hit_bin = BW'(l);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < fbeh_pkg::MaxBins; l++)
				count_q[l] <= '0;
		end else if (cmd.clear_all) begin
			for (int l = 0; l < fbeh_pkg::MaxBins; l++)
				count_q[l] <= '0;
		end else if (cmd.rmw && sts.hit && count_q[hit_bin] != fbeh_pkg::CountMax) begin
			count_q[hit_bin] <= count_q[hit_bin] + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_q <= '0;
		else if (cmd.rd_start)
			rd_q <= '0;
		else if (cmd.rd_next)
			rd_q <= rd_q + 1'b1;
	end

	assign sts.rd_last = ((BW+1)'(rd_q) + 1'b1) == used;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			bin_index <= rd_q;
			bin_total <= count_q[rd_q];
			last      <= sts.rd_last;
		end
	end

	`ASSERT_CLK(a_sat, clk, arst_n, (cmd.rmw && sts.hit && !cmd.clear_all && count_q[hit_bin] == fbeh_pkg::CountMax) |=> (count_q[$past(hit_bin)] == fbeh_pkg::CountMax), "sat")
	`ASSERT_CLK(a_rd_range, clk, arst_n, cmd.out_load |-> ((BW+1)'(rd_q) < used), "rd range")
endmodule

@@ hw/rtl/fbeh_ctrl.sv @@
// Controller state machine
`include "assert_macros.svh"
module fbeh_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] op,
	output logic out_valid,
	input  logic out_ready,
	output fbeh_pkg::cmd_t cmd,
	input  fbeh_pkg::sts_t sts
);
	fbeh_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbeh_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid_q;
		cmd = '0;
		in_ready = 1'b0;
		take = 1'b0;
		if (out_valid_q && out_ready)
			out_valid_d = 1'b0;
		unique case (state_q)
			fbeh_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				take = in_valid;
				if (take) begin
					unique case (fbeh_pkg::op_t'(op))
						fbeh_pkg::OP_LOAD: cmd.load_edge = 1'b1;
						fbeh_pkg::OP_SAMPLE: begin
							cmd.start_cmp = 1'b1;
							state_d = fbeh_pkg::ST_RMW;
						end
						fbeh_pkg::OP_READ: begin
							cmd.rd_start = 1'b1;
							state_d = fbeh_pkg::ST_RD_OUT;
						end
						default: ;
					endcase
				end
			end
			fbeh_pkg::ST_RMW: begin
				cmd.rmw = 1'b1;
				state_d = fbeh_pkg::ST_IDLE;
			end
			fbeh_pkg::ST_RD_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d = 1'b1;
					if (sts.rd_last) begin
						cmd.clear_all = 1'b1;
						state_d = fbeh_pkg::ST_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			default: state_d = fbeh_pkg::ST_IDLE;
		endcase
	end

	`ASSERT_CLK(a_busy, clk, arst_n, (state_q != fbeh_pkg::ST_IDLE) |-> !in_ready, "busy")
	`ASSERT_CLK(a_rmw, clk, arst_n, cmd.start_cmp |=> cmd.rmw, "rmw follows")
	`ASSERT_CLK(a_clr, clk, arst_n, cmd.clear_all |-> cmd.out_load && !take, "clear")
endmodule

@@ hw/rtl/float_bin_edge_histogram_unit.sv @@
// Top level of the float bin-edge histogram unit
//  channel  dir  payload
//  in       in   op, edge_slot, value_bits
//  out      out  bin_index, bin_total, last
//  cfg      in   data (bin_count; 0 acts as 1, above 32 as 32)
// Load edge writes edge slot 0..32. Sample: parallel edge compare, then counter update.
// Readout: one word per cycle for bin_count bins while out.ready is high; counts cleared
// with the last word. Output stalls hold the readout; input is held off until it ends.
// Reset clears all counts and sets bin_count to 32; edges are undefined until loaded.
module float_bin_edge_histogram_unit (
	input logic clk,
	input logic arst_n,
	fbeh_in_if.sink in,
	fbeh_out_if.source out,
	fbeh_cfg_if.sink cfg
);
	fbeh_pkg::cmd_t cmd;
	fbeh_pkg::sts_t sts;
	logic [fbeh_pkg::CfgW-1:0] bin_count_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bin_count_q <= fbeh_pkg::BinCountReset;
		else if (cfg.valid)
			bin_count_q <= cfg.data;
	end

	fbeh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready), .op(in.op),
		.out_valid(out.valid), .out_ready(out.ready),
		.cmd(cmd), .sts(sts)
	);

	fbeh_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.edge_slot(in.edge_slot), .value_bits(in.value_bits),
		.bin_count(bin_count_q),
		.bin_index(out.bin_index), .bin_total(out.bin_total), .last(out.last)
	);
endmodule
